FILE: rtl/pwu_pkg.sv
package pwu_pkg;

    // Store geometry.
    localparam int BANDS         = 256;
    localparam int MAX_PRECEDING = 15;
    localparam int PER_BAND      = MAX_PRECEDING + 3;
    localparam int DEPTH         = BANDS * PER_BAND;
    localparam int ADDR_W        = $clog2(DEPTH);

    // Field widths.
    localparam int WEIGHT_W = 22;
    localparam int DIFF_W   = 36;
    localparam int INDEX_W  = 5;
    localparam int BAND_W   = 8;
    localparam int COORD_W  = 16;

    // Configuration register indexes (byte address divided by four).
    localparam logic [2:0] REG_RESOLUTION = 3'd0;
    localparam logic [2:0] REG_PRECEDING  = 3'd1;
    localparam logic [2:0] REG_FULL_MODE  = 3'd2;
    localparam logic [2:0] REG_COLUMNS    = 3'd3;
    localparam logic [2:0] REG_INTERVAL   = 3'd4;
    localparam logic [2:0] REG_EXP_MIN    = 3'd5;
    localparam logic [2:0] REG_EXP_MAX    = 3'd6;
    localparam logic [2:0] REG_DEPTH      = 3'd7;

    // Request actions.
    localparam logic ACT_INIT   = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    // Configuration as seen by the datapath, resolution and depth already clamped.
    typedef struct packed {
        logic [4:0]        omega;
        logic [3:0]        preceding;
        logic              full;
        logic [15:0]       columns;
        logic [3:0]        interval_log2;
        logic signed [4:0] exp_min;
        logic signed [4:0] exp_max;
        logic [5:0]        depth;
    } cfg_t;

endpackage

FILE: rtl/predictor_weight_update_top.sv
// Predictor weight store with initialise and update requests.
// Configuration goes in over the APB-style port (registers at 4*i, pready
// tied high); the user is to change it only while no request is in flight, as
// the block does not enforce this. Input channel: in_valid/in_stall with the
// request fields; a request is taken at a clock edge with in_valid high and
// in_stall low. Output channel: out_valid/out_stall with weight_value and
// weight_index_out, one result per request, in request order.
// A request moves through stages one, two and three, then the output register.
// One request can be taken every cycle while no result is held at the output:
// the pipeline stages around the store (one read and one write per cycle, with
// forwarding of a write to the entry being read) sustain one read-modify-write per cycle.
// Reset clears the pipeline and loads the register defaults; the weight store
// is not cleared, so each entry must be initialised before it is updated.
// When out_stall is held, the result stays in the output register and the
// stages behind it keep filling; in_stall rises once all three are occupied.
module predictor_weight_update_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  logic [pwu_pkg::BAND_W-1:0]          band,
    input  logic [pwu_pkg::COORD_W-1:0]         column,
    input  logic [pwu_pkg::COORD_W-1:0]         row,
    input  logic [pwu_pkg::INDEX_W-1:0]         weight_index,
    input  logic                                error_negative,
    input  logic signed [pwu_pkg::DIFF_W-1:0]   local_difference,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pwu_pkg::WEIGHT_W-1:0] weight_value,
    output logic [pwu_pkg::INDEX_W-1:0]         weight_index_out
);
    import pwu_pkg::*;

    // Configuration registers.
    logic [4:0]  resolution_reg;
    logic [3:0]  preceding_reg;
    logic        full_mode_reg;
    logic [15:0] columns_reg;
    logic [3:0]  interval_reg;
    logic [4:0]  exp_min_reg;
    logic [4:0]  exp_max_reg;
    logic [5:0]  depth_reg;
    logic        cfg_write;
    cfg_t        cfg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= 5'd13;
            preceding_reg  <= 4'd3;
            full_mode_reg  <= 1'b1;
            columns_reg    <= 16'd256;
            interval_reg   <= 4'd6;
            exp_min_reg    <= 5'b11111;
            exp_max_reg    <= 5'd3;
            depth_reg      <= 6'd16;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_RESOLUTION: resolution_reg <= pwdata[4:0];
                REG_PRECEDING:  preceding_reg  <= pwdata[3:0];
                REG_FULL_MODE:  full_mode_reg  <= pwdata[0];
                REG_COLUMNS:    columns_reg    <= pwdata[15:0];
                REG_INTERVAL:   interval_reg   <= pwdata[3:0];
                REG_EXP_MIN:    exp_min_reg    <= pwdata[4:0];
                REG_EXP_MAX:    exp_max_reg    <= pwdata[4:0];
                REG_DEPTH:      depth_reg      <= pwdata[5:0];
                default:        ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[4:2])
            REG_RESOLUTION: prdata = {27'b0, resolution_reg};
            REG_PRECEDING:  prdata = {28'b0, preceding_reg};
            REG_FULL_MODE:  prdata = {31'b0, full_mode_reg};
            REG_COLUMNS:    prdata = {16'b0, columns_reg};
            REG_INTERVAL:   prdata = {28'b0, interval_reg};
            REG_EXP_MIN:    prdata = {27'b0, exp_min_reg};
            REG_EXP_MAX:    prdata = {27'b0, exp_max_reg};
            REG_DEPTH:      prdata = {26'b0, depth_reg};
            default:        prdata = '0;
        endcase
    end

    // Datapath view of the configuration, resolution and depth clamped to range.
    always_comb
    begin
        if (resolution_reg < 5'd4)
            cfg.omega = 5'd4;
        else if (resolution_reg > 5'd19)
            cfg.omega = 5'd19;
        else
            cfg.omega = resolution_reg;
        if (depth_reg < 6'd2)
            cfg.depth = 6'd2;
        else if (depth_reg > 6'd32)
            cfg.depth = 6'd32;
        else
            cfg.depth = depth_reg;
        cfg.preceding     = preceding_reg;
        cfg.full          = full_mode_reg;
        cfg.columns       = columns_reg;
        cfg.interval_log2 = interval_reg;
        cfg.exp_min       = $signed(exp_min_reg);
        cfg.exp_max       = $signed(exp_max_reg);
    end

    pwu_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .band             (band),
        .column           (column),
        .row              (row),
        .weight_index     (weight_index),
        .error_negative   (error_negative),
        .local_difference (local_difference),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .weight_value     (weight_value),
        .weight_index_out (weight_index_out)
    );

    // An index outside the store never yields a nonzero weight.
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (weight_index_out >= INDEX_W'(PER_BAND)) |-> weight_value == '0)
        else $error("Nonzero weight returned for an index outside the store.");

    // The pipeline only pushes back while a result is held at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("Input stalled without a held result at the output.");

endmodule

FILE: rtl/pwu_core.sv
module pwu_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pwu_pkg::cfg_t                       cfg,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  logic [pwu_pkg::BAND_W-1:0]          band,
    input  logic [pwu_pkg::COORD_W-1:0]         column,
    input  logic [pwu_pkg::COORD_W-1:0]         row,
    input  logic [pwu_pkg::INDEX_W-1:0]         weight_index,
    input  logic                                error_negative,
    input  logic signed [pwu_pkg::DIFF_W-1:0]   local_difference,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pwu_pkg::WEIGHT_W-1:0] weight_value,
    output logic [pwu_pkg::INDEX_W-1:0]         weight_index_out
);
    import pwu_pkg::*;

    localparam logic signed [36:0] DIFF_MAX = 37'sd16777216;
    localparam logic signed [36:0] DIFF_MIN = -37'sd16777216;
    localparam logic signed [59:0] STEP_MAX = 60'sd8388607;
    localparam logic signed [59:0] STEP_MIN = -60'sd8388608;

    // Weight store.
    logic [WEIGHT_W-1:0] mem [DEPTH];

    // Stage valid flags and their next values.
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic out_valid_reg, out_valid_next;

    // Stage one payload.
    logic                      s1_action_reg;
    logic [BAND_W-1:0]         s1_band_reg;
    logic [COORD_W-1:0]        s1_column_reg;
    logic [INDEX_W-1:0]        s1_index_reg;
    logic                      s1_neg_reg;
    logic signed [DIFF_W-1:0]  s1_diff_reg;
    logic signed [33:0]        s1_prod_reg;
    logic [ADDR_W-1:0]         s1_addr_reg;
    logic                      s1_store_reg;

    // Stage two payload.
    logic                      s2_action_reg;
    logic [INDEX_W-1:0]        s2_index_reg;
    logic                      s2_store_reg;
    logic                      s2_active_reg;
    logic [ADDR_W-1:0]         s2_addr_reg;
    logic signed [7:0]         s2_rho_reg;
    logic signed [36:0]        s2_v_reg;
    logic [18:0]               s2_init_reg;

    // Stage three payload and the read-back path.
    logic                      s3_action_reg;
    logic [INDEX_W-1:0]        s3_index_reg;
    logic                      s3_store_reg;
    logic                      s3_active_reg;
    logic [ADDR_W-1:0]         s3_addr_reg;
    logic [18:0]               s3_init_reg;
    logic signed [23:0]        s3_step_reg;
    logic [WEIGHT_W-1:0]       rdata_reg;
    logic                      fwd_hit_reg;
    logic [WEIGHT_W-1:0]       fwd_data_reg;

    // Output register.
    logic [WEIGHT_W-1:0]       weight_value_reg;
    logic [INDEX_W-1:0]        index_out_reg;

    // Handshake and stage movement.
    logic out_ready, s3_free, s3_move, s2_free, s2_move, s1_free, in_accept;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s3_free   = !s3_valid_reg || out_ready;
    assign s3_move   = s3_valid_reg && out_ready;
    assign s2_free   = !s2_valid_reg || s3_free;
    assign s2_move   = s2_valid_reg && s3_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign in_stall  = !s1_free;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next  = s1_free ? in_valid : s1_valid_reg;
        s2_valid_next  = s2_free ? s1_valid_reg : s2_valid_reg;
        s3_valid_next  = s3_free ? s2_valid_reg : s3_valid_reg;
        out_valid_next = out_ready ? s3_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage one: row offset product and store address.
    logic signed [16:0] row_m1;
    logic signed [16:0] cols_s;
    logic signed [33:0] prod_next;
    logic [ADDR_W-1:0]  addr_next;

    assign row_m1    = $signed({1'b0, row}) - 17'sd1;
    assign cols_s    = $signed({1'b0, cfg.columns});
    assign prod_next = row_m1 * cols_s;
    assign addr_next = ADDR_W'({band, 4'b0}) + ADDR_W'({band, 1'b0})
                     + ADDR_W'(weight_index);

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg <= action;
            s1_band_reg   <= band;
            s1_column_reg <= column;
            s1_index_reg  <= weight_index;
            s1_neg_reg    <= error_negative;
            s1_diff_reg   <= local_difference;
            s1_prod_reg   <= prod_next;
            s1_addr_reg   <= addr_next;
            s1_store_reg  <= (weight_index < INDEX_W'(PER_BAND));
        end
    end

    // Stage two: scaling exponent, signed difference, default weight and
    // which weights an update may touch.
    logic signed [34:0] pos;
    logic signed [34:0] term;
    logic signed [35:0] raw_exp;
    logic signed [35:0] lo_ext, hi_ext;
    logic signed [4:0]  clip_exp;
    logic signed [7:0]  rho_next;
    logic signed [36:0] diff_ext, v_next;
    logic [3:0]         zp;
    logic [18:0]        base;
    logic [5:0]         shift3;
    logic [18:0]        init_next;
    logic [INDEX_W-1:0] p_ext, p_plus3;
    logic               active_next;

    always_comb
    begin
        pos     = $signed({s1_prod_reg[33], s1_prod_reg}) + $signed({19'b0, s1_column_reg});
        term    = pos >>> cfg.interval_log2;
        lo_ext  = {{31{cfg.exp_min[4]}}, cfg.exp_min};
        hi_ext  = {{31{cfg.exp_max[4]}}, cfg.exp_max};
        raw_exp = $signed({term[34], term}) + lo_ext;
        if (raw_exp < lo_ext)
            clip_exp = cfg.exp_min;
        else if (raw_exp > hi_ext)
            clip_exp = cfg.exp_max;
        else
            clip_exp = raw_exp[4:0];
        rho_next = $signed({{3{clip_exp[4]}}, clip_exp}) + $signed({2'b0, cfg.depth})
                 - $signed({3'b0, cfg.omega});

        diff_ext = {s1_diff_reg[DIFF_W-1], s1_diff_reg};
        v_next   = s1_neg_reg ? -diff_ext : diff_ext;

        zp     = (s1_band_reg < {4'b0, cfg.preceding}) ? s1_band_reg[3:0] : cfg.preceding;
        base   = 19'd7 << (cfg.omega - 5'd3);
        shift3 = 6'({s1_index_reg, 1'b0}) + 6'(s1_index_reg);
        if (s1_index_reg == '0 && cfg.preceding != '0)
            init_next = base;
        else if (s1_index_reg != '0 && s1_index_reg < {1'b0, zp})
            init_next = base >> shift3;
        else
            init_next = '0;

        p_ext       = {1'b0, cfg.preceding};
        p_plus3     = p_ext + INDEX_W'(3);
        active_next = (s1_index_reg < {1'b0, zp})
                   || (cfg.full && s1_index_reg >= p_ext && s1_index_reg < p_plus3);
    end

    always_ff @(posedge clk)
    begin
        if (s2_free)
        begin
            s2_action_reg <= s1_action_reg;
            s2_index_reg  <= s1_index_reg;
            s2_store_reg  <= s1_store_reg;
            s2_active_reg <= active_next;
            s2_addr_reg   <= s1_addr_reg;
            s2_rho_reg    <= rho_next;
            s2_v_reg      <= v_next;
            s2_init_reg   <= init_next;
        end
    end

    // Stage three entry: shift by the exponent, halve with rounding, saturate.
    logic signed [36:0] v_clip;
    logic signed [59:0] v_wide, shifted, halved;
    logic [7:0]         neg_rho;
    logic signed [23:0] step_next;

    always_comb
    begin
        neg_rho = 8'(-s2_rho_reg);
        if (s2_v_reg > DIFF_MAX)
            v_clip = DIFF_MAX;
        else if (s2_v_reg < DIFF_MIN)
            v_clip = DIFF_MIN;
        else
            v_clip = s2_v_reg;
        if (s2_rho_reg > 8'sd0)
        begin
            v_wide  = {{23{s2_v_reg[36]}}, s2_v_reg};
            shifted = v_wide >>> s2_rho_reg[5:0];
        end
        else
        begin
            v_wide  = {{23{v_clip[36]}}, v_clip};
            shifted = v_wide <<< neg_rho[5:0];
        end
        halved = (shifted + 60'sd1) >>> 1;
        if (halved > STEP_MAX)
            step_next = STEP_MAX[23:0];
        else if (halved < STEP_MIN)
            step_next = STEP_MIN[23:0];
        else
            step_next = halved[23:0];
    end

    // Stage three: initialise, or add to the stored weight and clamp to the weight limit.
    logic [WEIGHT_W-1:0] old_w;
    logic signed [25:0]  sum, lim_pos, lim_neg, clamped;
    logic [WEIGHT_W-1:0] s3_result;
    logic                s3_wen;

    always_comb
    begin
        old_w   = fwd_hit_reg ? fwd_data_reg : rdata_reg;
        sum     = $signed({{4{old_w[WEIGHT_W-1]}}, old_w})
                + $signed({{2{s3_step_reg[23]}}, s3_step_reg});
        lim_pos = $signed(26'd1 << (cfg.omega + 5'd2));
        lim_neg = -lim_pos;
        if (sum < lim_neg)
            clamped = lim_neg;
        else if (sum > lim_pos - 26'sd1)
            clamped = lim_pos - 26'sd1;
        else
            clamped = sum;
        if (!s3_store_reg)
            s3_result = '0;
        else if (s3_action_reg == ACT_INIT)
            s3_result = {3'b0, s3_init_reg};
        else if (s3_active_reg)
            s3_result = clamped[WEIGHT_W-1:0];
        else
            s3_result = old_w;
        s3_wen = s3_store_reg && (s3_action_reg == ACT_INIT || s3_active_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s3_free)
        begin
            s3_action_reg <= s2_action_reg;
            s3_index_reg  <= s2_index_reg;
            s3_store_reg  <= s2_store_reg;
            s3_active_reg <= s2_active_reg;
            s3_addr_reg   <= s2_addr_reg;
            s3_init_reg   <= s2_init_reg;
            s3_step_reg   <= step_next;
        end
    end

    // Store read as a request enters stage three; a write to the same entry in
    // that cycle is forwarded, since the read returns the old contents.
    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            rdata_reg    <= mem[s2_addr_reg];
            fwd_hit_reg  <= s3_move && s3_wen && (s3_addr_reg == s2_addr_reg);
            fwd_data_reg <= s3_result;
        end
        if (s3_move && s3_wen)
        begin
            mem[s3_addr_reg] <= s3_result;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (s3_move)
        begin
            weight_value_reg <= s3_result;
            index_out_reg    <= s3_index_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign weight_value     = $signed(weight_value_reg);
    assign weight_index_out = index_out_reg;

endmodule

FILE: sim/pwu_weight_checker.sv
// Watches the register port and the request and result channels of the weight update
// block, keeps its own copy of the settings and the weight store, and checks
// every result against the value predicted for the oldest outstanding request.
module pwu_weight_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                action,
    input  logic [pwu_pkg::BAND_W-1:0]          band,
    input  logic [pwu_pkg::COORD_W-1:0]         column,
    input  logic [pwu_pkg::COORD_W-1:0]         row,
    input  logic [pwu_pkg::INDEX_W-1:0]         weight_index,
    input  logic                                error_negative,
    input  logic signed [pwu_pkg::DIFF_W-1:0]   local_difference,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [pwu_pkg::WEIGHT_W-1:0] weight_value,
    input  logic [pwu_pkg::INDEX_W-1:0]         weight_index_out,
    output int                                  fails,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [pwu_pkg::WEIGHT_W-1:0] weight;
        logic [pwu_pkg::INDEX_W-1:0]         index;
    } weight_result_t;

    weight_result_t                      pending_weights[$];
    pwu_pkg::cfg_t                       settings;
    logic signed [pwu_pkg::WEIGHT_W-1:0] weight_mirror [pwu_pkg::DEPTH];
    int                                  mismatches = 0;

    function automatic longint clamp(longint a, longint lo, longint hi);
        if (a < lo)
            return lo;
        if (a > hi)
            return hi;
        return a;
    endfunction

    // Weight left behind by one request, given the weight stored before it.
    function automatic longint weight_after_request(pwu_pkg::cfg_t c, longint stored,
                                                    logic act, longint b, longint x,
                                                    longint y, longint idx, logic neg,
                                                    longint diff);
        longint omega;
        longint depth;
        longint p;
        longint zp;
        longint base;
        longint cols;
        longint emin;
        longint emax;
        longint pos;
        longint rho;
        longint v;
        longint step;
        longint lim;
        logic   spectral;
        logic   directional;
        omega = clamp(longint'(c.omega), 4, 19);
        depth = clamp(longint'(c.depth), 2, 32);
        p     = c.preceding;
        zp    = (b < p) ? b : p;

        // Initialise: default weights fall off by three bits per spectral index.
        if (act == pwu_pkg::ACT_INIT)
        begin
            base = 64'sd7 <<< (omega - 3);
            if (idx == 0 && p > 0)
                return base;
            if (idx >= 1 && idx < zp)
                return base >>> (3 * idx);
            return 0;
        end

        // Weights outside the active set keep their value.
        spectral    = idx < zp;
        directional = c.full && idx >= p && idx < p + 3;
        if (!(spectral || directional))
            return stored;

        // Scaling exponent from the sample position.
        cols = c.columns;
        emin = c.exp_min;
        emax = c.exp_max;
        pos  = (y - 1) * cols + x;
        rho  = clamp(emin + (pos >>> c.interval_log2), emin, emax) + depth - omega;

        v = neg ? -diff : diff;
        if (rho > 0)
            step = v >>> rho;
        else
            step = clamp(v, -(64'sd1 <<< 24), 64'sd1 <<< 24) <<< (-rho);
        step = (step + 1) >>> 1;
        lim  = 64'sd1 <<< (omega + 2);
        return clamp(stored + step, -lim, lim - 1);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int             slot;
        longint         new_weight;
        weight_result_t want;
        if (!rst_n)
        begin
            settings.omega         = 5'd13;
            settings.preceding     = 4'd3;
            settings.full          = 1'b1;
            settings.columns       = 16'd256;
            settings.interval_log2 = 4'd6;
            settings.exp_min       = -5'sd1;
            settings.exp_max       = 5'sd3;
            settings.depth         = 6'd16;
            pending_weights.delete();
            outstanding <= 0;
        end
        else
        begin
            // Results leave in request order, so compare with the oldest prediction.
            if (out_valid && !out_stall)
            begin
                if (pending_weights.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got weight %0d index %0d",
                             $time, weight_value, weight_index_out);
                end
                else
                begin
                    want = pending_weights.pop_front();
                    if (weight_value !== want.weight)
                    begin
                        mismatches++;
                        $display("%0t: weight_value mismatch, expected %0d, got %0d",
                                 $time, want.weight, weight_value);
                    end
                    if (weight_index_out !== want.index)
                    begin
                        mismatches++;
                        $display("%0t: weight_index_out mismatch, expected %0d, got %0d",
                                 $time, want.index, weight_index_out);
                    end
                end
            end

            // Track register writes.
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    pwu_pkg::REG_RESOLUTION: settings.omega         = pwdata[4:0];
                    pwu_pkg::REG_PRECEDING:  settings.preceding     = pwdata[3:0];
                    pwu_pkg::REG_FULL_MODE:  settings.full          = pwdata[0];
                    pwu_pkg::REG_COLUMNS:    settings.columns       = pwdata[15:0];
                    pwu_pkg::REG_INTERVAL:   settings.interval_log2 = pwdata[3:0];
                    pwu_pkg::REG_EXP_MIN:    settings.exp_min       = pwdata[4:0];
                    pwu_pkg::REG_EXP_MAX:    settings.exp_max       = pwdata[4:0];
                    pwu_pkg::REG_DEPTH:      settings.depth         = pwdata[5:0];
                    default: ;
                endcase
            end

            // Predict the result of each accepted request and update the mirror.
            if (in_valid && !in_stall)
            begin
                new_weight = 0;
                if (band < pwu_pkg::BANDS && weight_index < pwu_pkg::PER_BAND)
                begin
                    slot = band * pwu_pkg::PER_BAND + weight_index;
                    new_weight = weight_after_request(settings, longint'(weight_mirror[slot]),
                                                      action, band, column, row,
                                                      weight_index, error_negative,
                                                      longint'(local_difference));
                    weight_mirror[slot] = new_weight[pwu_pkg::WEIGHT_W-1:0];
                end
                want.weight = new_weight[pwu_pkg::WEIGHT_W-1:0];
                want.index  = weight_index;
                pending_weights.push_back(want);
            end
            outstanding <= pending_weights.size();
        end
        fails <= mismatches;
    end

endmodule

FILE: sim/predictor_weight_update_top_tb.sv
module predictor_weight_update_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pwu_pkg::*;

    localparam int ITEMS_PER_SETTING = 144;
    localparam int SETTING_COUNT     = 8;

    logic                        clk              = 1'b0;
    logic                        rst_n            = 1'b0;
    logic                        psel             = 1'b0;
    logic                        penable          = 1'b0;
    logic                        pwrite           = 1'b0;
    logic [4:0]                  paddr            = '0;
    logic [31:0]                 pwdata           = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        in_valid         = 1'b0;
    logic                        in_stall;
    logic                        action           = ACT_INIT;
    logic [BAND_W-1:0]           band             = '0;
    logic [COORD_W-1:0]          column           = '0;
    logic [COORD_W-1:0]          row              = '0;
    logic [INDEX_W-1:0]          weight_index     = '0;
    logic                        error_negative   = 1'b0;
    logic signed [DIFF_W-1:0]    local_difference = '0;
    logic                        out_valid;
    logic                        out_stall        = 1'b0;
    logic signed [WEIGHT_W-1:0]  weight_value;
    logic [INDEX_W-1:0]          weight_index_out;
    int                          fails;
    int                          outstanding;

    // Which store entries have been initialised, so no update reads an unwritten one.
    bit primed [DEPTH];
    int preceding_now = 3;
    int burst_left    = 1;
    int stall_mode    = 0;
    int stall_left    = 0;
    int hot_bands [4];
    int n_init        = 0;
    int n_update      = 0;
    int n_outside     = 0;
    int n_settings    = 1;

    predictor_weight_update_top i_dut (.*);

    pwu_weight_checker i_checker (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The result side stalls in stretches of differing density.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (stall_left % 8) < 5;
        endcase
    end

    initial
    begin
        #2_000_000;
        $display("predictor_weight_update_top_tb NOT OK");
        $finish;
    end

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_PRECEDING)
            preceding_now = value[3:0];
    endtask

    // Hold off until every result is back and the pipeline has emptied.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic apply_setting(input int res, input int prec, input int full,
                                 input int cols, input int il, input int emin,
                                 input int emax, input int depth);
        drain();
        write_register(REG_RESOLUTION, {27'd0, res[4:0]});
        write_register(REG_PRECEDING,  {28'd0, prec[3:0]});
        write_register(REG_FULL_MODE,  {31'd0, full[0]});
        write_register(REG_COLUMNS,    {16'd0, cols[15:0]});
        write_register(REG_INTERVAL,   {28'd0, il[3:0]});
        write_register(REG_EXP_MIN,    {27'd0, emin[4:0]});
        write_register(REG_EXP_MAX,    {27'd0, emax[4:0]});
        write_register(REG_DEPTH,      {26'd0, depth[5:0]});
        n_settings++;
    endtask

    task automatic send_request(input logic act, input int b, input int idx, input int x,
                                input int y, input logic neg, input logic [DIFF_W-1:0] diff);
        @(negedge clk);
        in_valid         <= 1'b1;
        action           <= act;
        band             <= BAND_W'(b);
        weight_index     <= INDEX_W'(idx);
        column           <= COORD_W'(x);
        row              <= COORD_W'(y);
        error_negative   <= neg;
        local_difference <= diff;
        do @(posedge clk); while (in_stall);
        if (idx >= PER_BAND)
            n_outside++;
        else if (act == ACT_INIT)
        begin
            primed[b * PER_BAND + idx] = 1'b1;
            n_init++;
        end
        else
            n_update++;
    endtask

    // Requests go out in bursts, mostly short, now and then long and unbroken.
    task automatic pace();
        burst_left--;
        if (burst_left <= 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
    endtask

    // Random request: mostly well-formed work on a few busy bands, with repeats of
    // the same entry to exercise forwarding, and some requests outside the store.
    int last_band  = 0;
    int last_index = 0;

    task automatic random_request();
        int              b;
        int              idx;
        int              x;
        int              y;
        int              top_index;
        logic            act;
        logic [63:0]     raw;
        longint          mag;
        logic [DIFF_W-1:0] diff;
        if (primed[last_band * PER_BAND + last_index] && $urandom_range(0, 9) < 3)
        begin
            b   = last_band;
            idx = last_index;
        end
        else
        begin
            b = ($urandom_range(0, 9) < 7) ? hot_bands[$urandom_range(0, 3)]
                                           : $urandom_range(0, 255);
            top_index = (preceding_now + 2 < PER_BAND - 1) ? preceding_now + 2 : PER_BAND - 1;
            case ($urandom_range(0, 19))
                0:       idx = $urandom_range(PER_BAND, 31);
                1, 2, 3: idx = $urandom_range(0, PER_BAND - 1);
                default: idx = $urandom_range(0, top_index);
            endcase
        end

        if (idx < PER_BAND && !primed[b * PER_BAND + idx])
            act = ACT_INIT;
        else
            act = ($urandom_range(0, 4) == 0) ? ACT_INIT : ACT_UPDATE;

        case ($urandom_range(0, 3))
            0:       y = $urandom_range(0, 2);
            1:       y = $urandom_range(0, 65535);
            default: y = $urandom_range(0, 40);
        endcase
        x = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 65535);

        case ($urandom_range(0, 5))
            0:
            begin
                raw  = {$urandom, $urandom};
                diff = raw[DIFF_W-1:0];
            end
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       diff = 36'h7_FFFF_FFFF;
                    1:       diff = 36'h8_0000_0000;
                    2:       diff = '0;
                    default: diff = '1;
                endcase
            end
            default:
            begin
                mag = longint'($urandom);
                mag = mag >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    mag = -mag;
                diff = mag[DIFF_W-1:0];
            end
        endcase

        send_request(act, b, idx, x, y, 1'($urandom_range(0, 1)), diff);
        if (idx < PER_BAND)
        begin
            last_band  = b;
            last_index = idx;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests under the reset settings: default weights, saturation
        // both ways, rounding of minus one, weights left alone, outside the store.
        send_request(ACT_INIT,   0,   0,  0,     0,     1'b0, '0);
        send_request(ACT_INIT,   5,   0,  0,     0,     1'b0, '0);
        send_request(ACT_INIT,   5,   1,  0,     0,     1'b0, '0);
        send_request(ACT_INIT,   5,   2,  0,     0,     1'b0, '0);
        send_request(ACT_INIT,   5,   3,  0,     0,     1'b0, '0);
        send_request(ACT_INIT,   5,   6,  0,     0,     1'b0, '0);
        send_request(ACT_INIT,   5,   17, 0,     0,     1'b0, '0);
        send_request(ACT_INIT,   1,   1,  0,     0,     1'b0, '0);
        send_request(ACT_INIT,   255, 0,  65535, 65535, 1'b1, '1);
        pace();
        send_request(ACT_UPDATE, 5,   0,  0,     0,     1'b0, 36'h7_FFFF_FFFF);
        send_request(ACT_UPDATE, 5,   0,  65535, 65535, 1'b1, 36'h7_FFFF_FFFF);
        send_request(ACT_UPDATE, 5,   0,  1,     1,     1'b1, 36'h8_0000_0000);
        send_request(ACT_UPDATE, 5,   0,  1,     1,     1'b0, 36'h8_0000_0000);
        pace();
        send_request(ACT_UPDATE, 5,   1,  10,    2,     1'b0, '1);
        send_request(ACT_UPDATE, 5,   2,  10,    2,     1'b0, 36'd1);
        send_request(ACT_UPDATE, 5,   3,  300,   1,     1'b0, 36'd12345);
        send_request(ACT_UPDATE, 5,   6,  0,     0,     1'b0, 36'h7_FFFF_FFFF);
        send_request(ACT_UPDATE, 1,   1,  0,     0,     1'b0, 36'h7_FFFF_FFFF);
        send_request(ACT_UPDATE, 0,   0,  0,     0,     1'b1, 36'd99);
        pace();
        send_request(ACT_INIT,   5,   18, 0,     0,     1'b0, '0);
        send_request(ACT_UPDATE, 5,   31, 0,     0,     1'b0, 36'd7);
        send_request(ACT_UPDATE, 255, 0,  65535, 65535, 1'b0, 36'd5000);
        send_request(ACT_UPDATE, 255, 0,  65535, 65535, 1'b1, 36'd77);
        send_request(ACT_INIT,   0,   0,  0,     0,     1'b0, '0);
        pace();

        // Random requests under a sequence of settings, extremes first.
        for (int setting = 0; setting < SETTING_COUNT; setting++)
        begin
            case (setting)
                0: ;
                1: apply_setting(4, 0, 1, 1, 4, -6, 9, 32);
                2: apply_setting(19, 15, 0, 65535, 11, 9, -6, 2);
                3: apply_setting(31, 15, 1, 0, 15, -6, -6, 0);
                4: apply_setting(0, 7, 1, 640, 0, 0, 0, 63);
                5: apply_setting($urandom_range(4, 19), $urandom_range(0, 15),
                                 $urandom_range(0, 1), $urandom_range(1, 65535),
                                 $urandom_range(4, 11), $urandom_range(0, 15) - 6,
                                 $urandom_range(0, 15) - 6, $urandom_range(2, 32));
                default:
                    apply_setting($urandom_range(0, 31), $urandom_range(0, 15),
                                  $urandom_range(0, 1), $urandom_range(0, 65535),
                                  $urandom_range(0, 15), $urandom_range(0, 31),
                                  $urandom_range(0, 31), $urandom_range(0, 63));
            endcase
            hot_bands[0] = 0;
            hot_bands[1] = $urandom_range(1, 15);
            hot_bands[2] = $urandom_range(16, 254);
            hot_bands[3] = 255;
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                random_request();
                pace();
            end
        end

        drain();
        $display("Covered %0d initialise, %0d update and %0d out-of-store requests",
                 n_init, n_update, n_outside);
        $display("under %0d register settings, with bursty requests and stalled results.",
                 n_settings);
        if (fails == 0 && outstanding == 0)
            $display("predictor_weight_update_top_tb OK");
        else
            $display("predictor_weight_update_top_tb NOT OK");
        $finish;
    end

endmodule
